// ===== rtl/segment_sweep_area_classifier_assert.svh =====
// Assertion macros for the segment sweep area classifier.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SEGMENT_SWEEP_AREA_CLASSIFIER_ASSERT_SVH
`define SEGMENT_SWEEP_AREA_CLASSIFIER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSAC_ASSERT_HOLDS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define SSAC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SSAC_ASSERT_HOLDS(lbl, expr)
`define SSAC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/ssac_pkg.sv =====
// Types, codes and vertex tables of the segment sweep area classifier.
// No dependencies.
`default_nettype none
package ssac_pkg;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} pt_t;

	typedef struct packed {
		logic [4:0] code;
		pt_t  [3:0] p;
		logic       neg_x;
		logic       neg_y;
	} meta_t;

	localparam logic [4:0] T_NONE        = 5'd0;
	localparam logic [4:0] T_AT_START    = 5'd1;
	localparam logic [4:0] T_AT_END      = 5'd2;
	localparam logic [4:0] T_INSIDE      = 5'd3;
	localparam logic [4:0] S_AT_START    = 5'd4;
	localparam logic [4:0] S_AT_END      = 5'd8;
	localparam logic [4:0] S_INSIDE      = 5'd12;
	localparam logic [4:0] CODE_CROSS_BOTH = 5'd15;
	localparam logic [4:0] CODE_PARALLEL   = 5'd16;
	localparam logic [4:0] CODE_COLLINEAR  = 5'd17;

	localparam logic [0:0] REG_TOLERANCE = 1'b0;
	localparam logic [15:0] TOL_RESET = 16'd1;

	localparam logic [2:0] VX_CROSS = 3'd0;
	localparam logic [2:0] VX_P1    = 3'd1;
	localparam logic [2:0] VX_P2    = 3'd2;
	localparam logic [2:0] VX_P3    = 3'd3;
	localparam logic [2:0] VX_P4    = 3'd4;

	function automatic logic [2:0] vtx_count(input logic [4:0] code);
		unique case (code)
			5'd0, 5'd3, 5'd12, CODE_PARALLEL: return 3'd4;
			CODE_CROSS_BOTH:                  return 3'd6;
			CODE_COLLINEAR:                   return 3'd1;
			default:                          return 3'd3;
		endcase
	endfunction

	function automatic logic [2:0] vtx_pick(input logic [4:0] code, input logic [2:0] k);
		logic [7:0][2:0] lst;
		lst = '0;
		unique case (code)
			5'd0, 5'd3, 5'd12, CODE_PARALLEL: begin
				lst[0] = VX_P1; lst[1] = VX_P2; lst[2] = VX_P4; lst[3] = VX_P3;
			end
			5'd1, 5'd5, 5'd6, 5'd7, 5'd13: begin
				lst[0] = VX_P1; lst[1] = VX_P2; lst[2] = VX_P4;
			end
			5'd2, 5'd9, 5'd10, 5'd14: begin
				lst[0] = VX_P1; lst[1] = VX_P2; lst[2] = VX_P3;
			end
			5'd4: begin
				lst[0] = VX_P2; lst[1] = VX_P3; lst[2] = VX_P4;
			end
			5'd8, 5'd11: begin
				lst[0] = VX_P1; lst[1] = VX_P3; lst[2] = VX_P4;
			end
			CODE_CROSS_BOTH: begin
				lst[0] = VX_CROSS; lst[1] = VX_P1; lst[2] = VX_P3;
				lst[3] = VX_CROSS; lst[4] = VX_P2; lst[5] = VX_P4;
			end
			default: lst = '0;
		endcase
		return lst[k];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/segment_sweep_area_classifier.sv =====
// Segment sweep area classifier: crossing classification and swept polygon vertices.
// Depends on ssac_pkg and segment_sweep_area_classifier_assert.svh.
// A request passes the input stages, the divider and the vertex sequencer register.
// A request may enter every cycle while in_stall is low; it yields 1, 3, 4
// or 6 vertices, one per cycle unless stalled, from the output vertex sequencer.
// The crossing point comes from a 17-stage divider, two quotient bits per stage.
// Reset clears the valid bits, the vertex counter and sets tolerance to 1.
`default_nettype none
`include "segment_sweep_area_classifier_assert.svh"
module segment_sweep_area_classifier
	import ssac_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire  [2:0]         paddr,
	input  wire  [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire signed [31:0]  old_start_x,
	input  wire signed [31:0]  old_start_y,
	input  wire signed [31:0]  old_end_x,
	input  wire signed [31:0]  old_end_y,
	input  wire signed [31:0]  new_start_x,
	input  wire signed [31:0]  new_start_y,
	input  wire signed [31:0]  new_end_x,
	input  wire signed [31:0]  new_end_y,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [4:0]         case_code,
	output logic               polygon_number,
	output logic signed [31:0] vertex_x,
	output logic signed [31:0] vertex_y,
	output logic               no_polygon,
	output logic               last_vertex
);

	localparam int CW     = 68 + FRAC_BITS + 16;
	localparam int QW     = 34;
	localparam int NW     = 100;
	localparam int DW     = 67;
	localparam int DIV_ST = QW / 2;

	typedef struct packed {
		logic          q;
		logic [NW-1:0] r;
	} div_t;

	function automatic div_t div_step(input logic [NW-1:0] r, input logic [DW-1:0] d,
		input int sh);
		div_t          res;
		logic [NW-1:0] ds;
		ds = NW'(d) << sh;
		res.q = (r >= ds);
		res.r = res.q ? (r - ds) : r;
		return res;
	endfunction

	logic [15:0] tol_q;
	logic        adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_TOLERANCE) begin
			tol_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TOLERANCE) ? {16'd0, tol_q} : 32'd0;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	pt_t [3:0] pts_s1, pts_s2, pts_s3, pts_s4, pts_s5, pts_s6;
	logic signed [32:0] a_s2, b_s2, c_s2, d_s2, e_s2, f_s2;
	logic signed [32:0] a_s3, b_s3, e_s3, a_s4, b_s4, e_s4;
	logic signed [65:0] bf_s3, ce_s3, af_s3, cd_s3, bd_s3, ae_s3;
	logic signed [66:0] det_s4, dxn_s4, dyn_s4;
	logic [66:0] adet_s5, adxn_s5, adyn_s5, adet_s6, adxn_s6, adyn_s6;
	logic [67:0] adxm_s5, adym_s5, adxm_s6, adym_s6;
	logic [32:0] aa_s5, ab_s5, ae_s5;
	logic        negx_s5, negy_s5, sxn_s5, syn_s5, sdet_s5, zxn_s5, zyn_s5;
	logic [82:0] tdet_s6;
	logic [48:0] tb_s6;
	logic        inx_s6, iny_s6, par_s6, smallb_s6, smalla_s6, negx_s6, negy_s6;
	logic [66:0] pxl_s6, pyl_s6;
	logic [65:0] pxh_s6, pyh_s6;

	logic              dv_v_s    [DIV_ST+1];
	meta_t             dv_meta_s [DIV_ST+1];
	logic [NW-1:0]     dv_rx_s   [DIV_ST+1];
	logic [NW-1:0]     dv_ry_s   [DIV_ST+1];
	logic [QW-1:0]     dv_qx_s   [DIV_ST+1];
	logic [QW-1:0]     dv_qy_s   [DIV_ST+1];
	logic [DW-1:0]     dv_d_s    [DIV_ST+1];

	logic signed [66:0] dxm_c, dym_c;
	logic        near0x_c, near1x_c, near0y_c, near1y_c, col_c;
	logic [4:0]  tcx_c, tcy_c, code_c;

	always_comb begin
		dxm_c = dxn_s4 - det_s4;
		dym_c = dyn_s4 - det_s4;
		near0x_c = (CW'(adxn_s6) << FRAC_BITS) <= CW'(tdet_s6);
		near1x_c = (CW'(adxm_s6) << FRAC_BITS) <= CW'(tdet_s6);
		near0y_c = (CW'(adyn_s6) << FRAC_BITS) <= CW'(tdet_s6);
		near1y_c = (CW'(adym_s6) << FRAC_BITS) <= CW'(tdet_s6);
		col_c = smallb_s6 ? smalla_s6 : (CW'(adyn_s6) <= CW'(tb_s6));
		priority if (near1x_c) tcx_c = T_AT_END;
		else if (near0x_c)     tcx_c = T_AT_START;
		else if (inx_s6)       tcx_c = T_INSIDE;
		else                   tcx_c = T_NONE;
		priority if (near0y_c) tcy_c = S_AT_START;
		else if (near1y_c)     tcy_c = S_AT_END;
		else if (iny_s6)       tcy_c = S_INSIDE;
		else                   tcy_c = T_NONE;
		if (par_s6) code_c = col_c ? CODE_COLLINEAR : CODE_PARALLEL;
		else        code_c = tcx_c + tcy_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
			dv_v_s[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pts_s1[0] <= '{x: old_start_x, y: old_start_y};
			pts_s1[1] <= '{x: old_end_x,   y: old_end_y};
			pts_s1[2] <= '{x: new_start_x, y: new_start_y};
			pts_s1[3] <= '{x: new_end_x,   y: new_end_y};

			pts_s2 <= pts_s1;
			a_s2 <= 33'(pts_s1[0].x) - 33'(pts_s1[2].x);
			b_s2 <= 33'(pts_s1[0].x) - 33'(pts_s1[1].x);
			c_s2 <= 33'(pts_s1[3].x) - 33'(pts_s1[2].x);
			d_s2 <= 33'(pts_s1[0].y) - 33'(pts_s1[2].y);
			e_s2 <= 33'(pts_s1[0].y) - 33'(pts_s1[1].y);
			f_s2 <= 33'(pts_s1[3].y) - 33'(pts_s1[2].y);

			pts_s3 <= pts_s2;
			bf_s3 <= 66'(b_s2) * 66'(f_s2);
			ce_s3 <= 66'(c_s2) * 66'(e_s2);
			af_s3 <= 66'(a_s2) * 66'(f_s2);
			cd_s3 <= 66'(c_s2) * 66'(d_s2);
			bd_s3 <= 66'(b_s2) * 66'(d_s2);
			ae_s3 <= 66'(a_s2) * 66'(e_s2);
			a_s3 <= a_s2; b_s3 <= b_s2; e_s3 <= e_s2;

			pts_s4 <= pts_s3;
			det_s4 <= 67'(bf_s3) - 67'(ce_s3);
			dxn_s4 <= 67'(af_s3) - 67'(cd_s3);
			dyn_s4 <= 67'(bd_s3) - 67'(ae_s3);
			a_s4 <= a_s3; b_s4 <= b_s3; e_s4 <= e_s3;

			pts_s5 <= pts_s4;
			adet_s5 <= det_s4[66] ? 67'(-det_s4) : 67'(det_s4);
			adxn_s5 <= dxn_s4[66] ? 67'(-dxn_s4) : 67'(dxn_s4);
			adyn_s5 <= dyn_s4[66] ? 67'(-dyn_s4) : 67'(dyn_s4);
			adxm_s5 <= dxm_c[66] ? (68'd0 - 68'(dxm_c)) : 68'(dxm_c);
			adym_s5 <= dym_c[66] ? (68'd0 - 68'(dym_c)) : 68'(dym_c);
			aa_s5 <= a_s4[32] ? 33'(-a_s4) : 33'(a_s4);
			ab_s5 <= b_s4[32] ? 33'(-b_s4) : 33'(b_s4);
			ae_s5 <= e_s4[32] ? 33'(-e_s4) : 33'(e_s4);
			negx_s5 <= ~b_s4[32] ^ dxn_s4[66] ^ det_s4[66];
			negy_s5 <= ~e_s4[32] ^ dxn_s4[66] ^ det_s4[66];
			sxn_s5 <= dxn_s4[66];
			syn_s5 <= dyn_s4[66];
			sdet_s5 <= det_s4[66];
			zxn_s5 <= (dxn_s4 == '0);
			zyn_s5 <= (dyn_s4 == '0);

			pts_s6 <= pts_s5;
			tdet_s6 <= 83'(tol_q) * 83'(adet_s5);
			tb_s6 <= 49'(tol_q) * 49'(ab_s5);
			inx_s6 <= !zxn_s5 && (sxn_s5 == sdet_s5) && (adxn_s5 < adet_s5);
			iny_s6 <= !zyn_s5 && (syn_s5 == sdet_s5) && (adyn_s5 < adet_s5);
			par_s6 <= adet_s5 <= 67'(tol_q);
			smallb_s6 <= ab_s5 <= 33'(tol_q);
			smalla_s6 <= aa_s5 <= 33'(tol_q);
			adet_s6 <= adet_s5; adxn_s6 <= adxn_s5; adyn_s6 <= adyn_s5;
			adxm_s6 <= adxm_s5; adym_s6 <= adym_s5;
			pxl_s6 <= 67'(ab_s5) * 67'(adxn_s5[33:0]);
			pxh_s6 <= 66'(ab_s5) * 66'(adxn_s5[66:34]);
			pyl_s6 <= 67'(ae_s5) * 67'(adxn_s5[33:0]);
			pyh_s6 <= 66'(ae_s5) * 66'(adxn_s5[66:34]);
			negx_s6 <= negx_s5; negy_s6 <= negy_s5;

			dv_meta_s[0].code  <= code_c;
			dv_meta_s[0].p     <= pts_s6;
			dv_meta_s[0].neg_x <= negx_s6;
			dv_meta_s[0].neg_y <= negy_s6;
			dv_rx_s[0] <= NW'(pxl_s6) + (NW'(pxh_s6) << 34);
			dv_ry_s[0] <= NW'(pyl_s6) + (NW'(pyh_s6) << 34);
			dv_qx_s[0] <= '0;
			dv_qy_s[0] <= '0;
			dv_d_s[0]  <= adet_s6;
		end
	end

	for (genvar j = 0; j < DIV_ST; j++) begin : g_div
		localparam int HI = QW - 1 - 2 * j;
		div_t x1, x2, y1, y2;
		logic [QW-1:0] qx, qy;

		always_comb begin
			x1 = div_step(dv_rx_s[j], dv_d_s[j], HI);
			x2 = div_step(x1.r, dv_d_s[j], HI - 1);
			y1 = div_step(dv_ry_s[j], dv_d_s[j], HI);
			y2 = div_step(y1.r, dv_d_s[j], HI - 1);
			qx = dv_qx_s[j];
			qy = dv_qy_s[j];
			qx[HI] = x1.q; qx[HI-1] = x2.q;
			qy[HI] = y1.q; qy[HI-1] = y2.q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_meta_s[j+1] <= dv_meta_s[j];
				dv_d_s[j+1]    <= dv_d_s[j];
				dv_rx_s[j+1]   <= x2.r;
				dv_ry_s[j+1]   <= y2.r;
				dv_qx_s[j+1]   <= qx;
				dv_qy_s[j+1]   <= qy;
			end
		end
	end

	meta_t              fin_meta;
	logic signed [35:0] sum_x, sum_y;
	pt_t                cross_pt;

	always_comb begin
		fin_meta = dv_meta_s[DIV_ST];
		sum_x = 36'(fin_meta.p[0].x) + (fin_meta.neg_x ?
			(36'd0 - 36'(dv_qx_s[DIV_ST])) : 36'(dv_qx_s[DIV_ST]));
		sum_y = 36'(fin_meta.p[0].y) + (fin_meta.neg_y ?
			(36'd0 - 36'(dv_qy_s[DIV_ST])) : 36'(dv_qy_s[DIV_ST]));
		if (sum_x[35:31] == '0 || sum_x[35:31] == '1) cross_pt.x = sum_x[31:0];
		else cross_pt.x = sum_x[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		if (sum_y[35:31] == '0 || sum_y[35:31] == '1) cross_pt.y = sum_y[31:0];
		else cross_pt.y = sum_y[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	end

	logic       ser_v_q;
	logic [4:0] ser_code_q;
	pt_t  [4:0] ser_vtx_q;
	logic [2:0] ser_k_q;
	logic [2:0] pick;
	logic       ser_last;

	assign ser_last = (ser_k_q == vtx_count(ser_code_q) - 3'd1);
	assign adv      = !ser_v_q || (!out_stall && ser_last);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			ser_k_q <= '0;
		end else if (adv) begin
			ser_v_q <= dv_v_s[DIV_ST];
			ser_k_q <= '0;
		end else if (!out_stall) begin
			ser_k_q <= ser_k_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ser_code_q   <= fin_meta.code;
			ser_vtx_q[0] <= cross_pt;
			ser_vtx_q[1] <= fin_meta.p[0];
			ser_vtx_q[2] <= fin_meta.p[1];
			ser_vtx_q[3] <= fin_meta.p[2];
			ser_vtx_q[4] <= fin_meta.p[3];
		end
	end

	always_comb begin
		pick           = vtx_pick(ser_code_q, ser_k_q);
		out_valid      = ser_v_q;
		case_code      = ser_code_q;
		no_polygon     = (ser_code_q == CODE_COLLINEAR);
		last_vertex    = ser_last;
		polygon_number = (ser_code_q == CODE_CROSS_BOTH) && (ser_k_q >= 3'd3);
		if (no_polygon) begin
			vertex_x = '0;
			vertex_y = '0;
		end else begin
			vertex_x = ser_vtx_q[pick].x;
			vertex_y = ser_vtx_q[pick].y;
		end
	end

	`SSAC_ASSERT_NEXT(a_hold_item, out_valid && !out_stall && !last_vertex, out_valid)
	`SSAC_ASSERT_HOLDS(a_empty_last, !(out_valid && no_polygon) || (last_vertex && case_code == CODE_COLLINEAR))
	`SSAC_ASSERT_HOLDS(a_second_poly, !(out_valid && polygon_number) || case_code == CODE_CROSS_BOTH)
	`SSAC_ASSERT_HOLDS(a_stall_cause, !in_stall || (out_valid && (out_stall || !last_vertex)))

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the segment sweep area classifier.
// Predicts crossing class and swept polygon vertices per request and checks every result.
// Depends on ssac_pkg and the segment_sweep_area_classifier RTL.
`timescale 1ns / 1ps
module testbench
	import ssac_pkg::*;
();

	typedef struct packed {
		logic [4:0]         code;
		logic               poly;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               nopoly;
		logic               last;
	} vertex_t;

	typedef logic signed [31:0] coord8_t [8];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] old_start_x = '0, old_start_y = '0, old_end_x = '0, old_end_y = '0;
	logic signed [31:0] new_start_x = '0, new_start_y = '0, new_end_x = '0, new_end_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [4:0] case_code;
	logic polygon_number;
	logic signed [31:0] vertex_x, vertex_y;
	logic no_polygon, last_vertex;

	logic [15:0] tolerance = TOL_RESET;
	vertex_t expected_vertices[$];
	int errors = 0;
	int cycles = 0;
	int hold_off = 0;
	int out_wait = 0;

	segment_sweep_area_classifier uut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("testbench failed");
			$finish;
		end
	end

	function automatic logic signed [127:0] mag(input logic signed [127:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic near_param(input logic signed [127:0] n,
		input logic signed [127:0] d);
		return (mag(n) <<< 16) <= $signed({112'd0, tolerance}) * mag(d);
	endfunction

	function automatic logic inside_param(input logic signed [127:0] n,
		input logic signed [127:0] d);
		return n != 0 && ((n < 0) == (d < 0)) && mag(n) < mag(d);
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	task automatic queue_vertex(input vertex_t r);
		expected_vertices = {expected_vertices, r};
	endtask

	task automatic predict_vertices(input coord8_t c);
		logic signed [127:0] px[5], py[5];
		logic signed [127:0] a, b, cc, d, e, f, det, dxn, dyn, tol, ddx, cr;
		logic col;
		logic [4:0] code;
		int cnt;
		logic [2:0] v;
		vertex_t r;
		for (int i = 0; i < 4; i++) begin
			px[i + 1] = c[2 * i];
			py[i + 1] = c[2 * i + 1];
		end
		px[0] = 0;
		py[0] = 0;
		tol = $signed({112'd0, tolerance});
		a = px[1] - px[3]; b = px[1] - px[2]; cc = px[4] - px[3];
		d = py[1] - py[3]; e = py[1] - py[2]; f = py[4] - py[3];
		det = b * f - cc * e;
		if (mag(det) <= tol) begin
			ddx = px[2] - px[1];
			if (mag(ddx) <= tol) col = mag(px[3] - px[1]) <= tol;
			else begin
				cr = (py[3] - py[1]) * ddx - (py[2] - py[1]) * (px[3] - px[1]);
				col = mag(cr) <= tol * mag(ddx);
			end
			if (col) begin
				r = '{CODE_COLLINEAR, 1'b0, 32'sd0, 32'sd0, 1'b1, 1'b1};
				queue_vertex(r);
				return;
			end
			code = CODE_PARALLEL;
		end else begin
			code = T_NONE;
			dxn = a * f - cc * d;
			dyn = b * d - a * e;
			if (inside_param(dxn, det)) code = T_INSIDE;
			if (near_param(dxn, det)) code = T_AT_START;
			if (near_param(dxn - det, det)) code = T_AT_END;
			if (near_param(dyn, det)) code += S_AT_START;
			else if (near_param(dyn - det, det)) code += S_AT_END;
			else if (inside_param(dyn, det)) code += S_INSIDE;
			if (code == CODE_CROSS_BOTH) begin
				px[0] = clamp32(px[1] + ((px[2] - px[1]) * dxn) / det);
				py[0] = clamp32(py[1] + ((py[2] - py[1]) * dxn) / det);
			end
		end
		cnt = (code == CODE_CROSS_BOTH) ? 6 : (code == 0 || code == 3 || code == 12 ||
			code == CODE_PARALLEL) ? 4 : 3;
		for (int k = 0; k < cnt; k++) begin
			case (code)
				5'd0, 5'd3, 5'd12, CODE_PARALLEL:
					v = (k == 0) ? VX_P1 : (k == 1) ? VX_P2 : (k == 2) ? VX_P4 : VX_P3;
				5'd2, 5'd9, 5'd10, 5'd14:
					v = (k == 0) ? VX_P1 : (k == 1) ? VX_P2 : VX_P3;
				5'd4: v = (k == 0) ? VX_P2 : (k == 1) ? VX_P3 : VX_P4;
				5'd8, 5'd11: v = (k == 0) ? VX_P1 : (k == 1) ? VX_P3 : VX_P4;
				CODE_CROSS_BOTH: begin
					case (k)
						0, 3: v = VX_CROSS;
						1: v = VX_P1;
						2: v = VX_P3;
						4: v = VX_P2;
						default: v = VX_P4;
					endcase
				end
				default: v = (k == 0) ? VX_P1 : (k == 1) ? VX_P2 : VX_P4;
			endcase
			r.code = code;
			r.poly = (code == CODE_CROSS_BOTH && k >= 3);
			r.vx = px[v][31:0];
			r.vy = py[v][31:0];
			r.nopoly = 1'b0;
			r.last = (k + 1 == cnt);
			queue_vertex(r);
		end
	endtask

	always @(posedge clk) begin
		vertex_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_vertices.size() == 0) begin
				$error("unexpected result, case_code %0d", case_code);
				errors++;
			end else begin
				x = expected_vertices.pop_front();
				if (case_code !== x.code) begin
					$error("case_code expected %0d actual %0d", x.code, case_code); errors++;
				end
				if (polygon_number !== x.poly) begin
					$error("polygon_number expected %0d actual %0d", x.poly, polygon_number);
					errors++;
				end
				if (vertex_x !== x.vx) begin
					$error("vertex_x expected %h actual %h", x.vx, vertex_x); errors++;
				end
				if (vertex_y !== x.vy) begin
					$error("vertex_y expected %h actual %h", x.vy, vertex_y); errors++;
				end
				if (no_polygon !== x.nopoly) begin
					$error("no_polygon expected %0d actual %0d", x.nopoly, no_polygon); errors++;
				end
				if (last_vertex !== x.last) begin
					$error("last_vertex expected %0d actual %0d", x.last, last_vertex); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		int w;
		if (hold_off > 0) begin
			out_stall <= 1'b1;
			hold_off <= hold_off - 1;
		end else if (out_valid && !out_stall) begin
			w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 7);
			out_stall <= (w != 0);
			out_wait <= (w > 0) ? w - 1 : 0;
		end else if (out_wait > 0) begin
			out_stall <= 1'b1;
			out_wait <= out_wait - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_request(input coord8_t c);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		old_start_x <= c[0]; old_start_y <= c[1]; old_end_x <= c[2]; old_end_y <= c[3];
		new_start_x <= c[4]; new_start_y <= c[5]; new_end_x <= c[6]; new_end_y <= c[7];
		in_valid <= 1'b1;
		predict_vertices(c);
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_tolerance(input logic [15:0] value);
		in_valid <= 1'b0;
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd4 * REG_TOLERANCE; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		tolerance = value;
	endtask

	function automatic logic signed [31:0] rand_coord(input int mode);
		case (mode)
			0: return $urandom();
			1: return ($signed($urandom_range(0, 40)) <<< 16) - (32'sd20 <<< 16);
			default: return $signed($urandom_range(0, 400)) - 32'sd200;
		endcase
	endfunction

	task automatic test_directed();
		coord8_t c;
		int u = 65536;
		c = '{0, 0, 4 * u, 0, 0, 2 * u, 4 * u, 2 * u}; send_request(c);
		c = '{0, 0, 4 * u, 4 * u, 0, 4 * u, 4 * u, 0}; send_request(c);
		c = '{0, 0, 4 * u, 0, 8 * u, 0, 12 * u, 0}; send_request(c);
		c = '{0, 0, 0, 4 * u, 0, 8 * u, 0, 9 * u}; send_request(c);
		c = '{0, 0, 4 * u, 0, 0, 0, 0, 4 * u}; send_request(c);
		c = '{0, 0, 4 * u, 0, 4 * u, 0, 4 * u, 4 * u}; send_request(c);
		c = '{0, 0, 4 * u, 0, 2 * u, 0, 2 * u, 4 * u}; send_request(c);
		c = '{0, 0, 4 * u, 0, 0, -2 * u, 0, 2 * u}; send_request(c);
		c = '{0, 0, 4 * u, 0, 4 * u, -2 * u, 4 * u, 2 * u}; send_request(c);
		c = '{0, 0, 4 * u, 0, 0, 0, 9 * u, 3 * u}; send_request(c);
		c = '{0, 0, 4 * u, 0, 9 * u, 1 * u, 9 * u, 3 * u}; send_request(c);
		c = '{0, 0, 4 * u, 0, 2 * u, 1 * u, 2 * u, 3 * u}; send_request(c);
		c = '{0, 0, 4 * u, 0, 2 * u, 2 * u, 0, 4 * u}; send_request(c);
		c = '{0, 0, 4 * u, 4 * u, 4 * u, 4 * u, 9 * u, 0}; send_request(c);
		c = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000}; send_request(c);
		c = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 32'sh80000001, 32'sh80000000}; send_request(c);
		c = '{32'sh80000000, 0, 32'sh7fffffff, 1, 0, 32'sh80000000, 1, 32'sh7fffffff};
		send_request(c);
		c = '{-1, -1, -1, -1, -1, -1, -1, -1}; send_request(c);
	endtask

	task automatic test_random(input int count);
		coord8_t c;
		int mode;
		for (int n = 0; n < count; n++) begin
			mode = $urandom_range(0, 9);
			for (int i = 0; i < 8; i++) c[i] = rand_coord(mode < 2 ? 0 : mode < 7 ? 1 : 2);
			if (mode == 9) begin
				c[4] = c[0] + $signed($urandom_range(0, 4)) - 2;
				c[5] = c[1] + $signed($urandom_range(0, 4)) - 2;
				c[6] = c[2] + (c[4] - c[0]);
				c[7] = c[3] + (c[5] - c[1]);
			end else if (mode == 8) begin
				c[6] = c[4] + (c[2] - c[0]);
				c[7] = c[5] + (c[3] - c[1]);
			end
			send_request(c);
		end
	endtask

	task automatic test_backpressure();
		coord8_t c;
		hold_off = 300;
		for (int n = 0; n < 20; n++) begin
			for (int i = 0; i < 8; i++) c[i] = rand_coord(1);
			send_request(c);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(50);
		test_backpressure();
		write_tolerance(16'd0);
		test_directed();
		test_random(50);
		write_tolerance(16'hffff);
		test_random(40);
		write_tolerance(16'd300);
		test_random(40);
		in_valid <= 1'b0;
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) $display("testbench passed");
		else $display("testbench failed");
		$finish;
	end
endmodule

// ===== segment_sweep_area_classifier.f =====
+incdir+rtl
rtl/ssac_pkg.sv
rtl/segment_sweep_area_classifier.sv
tb/testbench.sv
